// File: design/shspc_pkg.sv
// package: constants, codes and types for the save header seed patch checksum block
`timescale 1ns / 1ps

package shspc_pkg;

  localparam int MAX_FILE_BYTES_DEF = 65535;

  localparam int POS_W = 16;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 160;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] SIGNATURE_VALUE = 32'hAA55AA55;
  localparam logic [31:0] VERSION_NEW_OFFSET = 32'h0000_0069;
  localparam logic [POS_W-1:0] SEED_OFF_NEW = 16'h009B;
  localparam logic [POS_W-1:0] SEED_OFF_OLD = 16'h00AB;
  localparam logic [POS_W-1:0] CHECKSUM_POS = 16'h000C;
  localparam logic [POS_W-1:0] VERSION_POS = 16'h0004;

  // register indexes on the configuration channel
  typedef enum logic {
    CFG_WRITE_SEED = 1'b0,
    CFG_REPL_SEED  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_SHORT        = 2'd1,
    ST_BAD_SIG      = 2'd2,
    ST_NO_SEED_ROOM = 2'd3
  } status_t;

  // result fields, first member in the highest bits of the packed struct
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] file_size;
    logic [31:0] version_word;
    logic [31:0] old_seed;
    logic [31:0] stored_checksum;
    logic [31:0] computed_checksum;
    logic        checksum_ok;
    status_t     status;
    logic [7:0]  out_byte;
  } result_t;

endpackage

// File: design/save_header_seed_patch_checksum.sv
// top level: byte stream seed patcher with rotate-add checksum
// rotate-add and position logic feed the output register combinationally
// throughput: 1 item per cycle while s_tready is high
// s_tready stays high while the output register is empty or being taken
// reset (rst, synchronous): clears stream state, config registers and output valid
// a file ends on the item with s_tlast set; the next item starts a new file
`timescale 1ns / 1ps

module save_header_seed_patch_checksum #(
  parameter int MAX_FILE_BYTES = shspc_pkg::MAX_FILE_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [shspc_pkg::IN_TDATA_W-1:0]   s_tdata,  // data_byte[7:0]
  input  logic                               s_tlast,  // end_of_file
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_byte[7:0], status[9:8], checksum_ok[10], computed_checksum[42:11],
  // stored_checksum[74:43], old_seed[106:75], version_word[138:107],
  // file_size[154:139], zero[159:155]
  output logic [shspc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                               m_tlast,  // is_final
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  shspc_pkg::cfg_index_t              cfg_index,
  input  logic [shspc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import shspc_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FILE_BYTES);

  logic              write_seed;
  logic [31:0]       repl_seed;

  logic [POS_W-1:0]  byte_position;
  logic [31:0]       checksum_accum;
  logic [31:0]       signature_word;
  logic [31:0]       version_reg;
  logic [31:0]       stored_checksum_reg;
  logic [31:0]       seed_reg;

  logic [POS_W-1:0]  byte_position_next;
  logic [31:0]       checksum_accum_next;
  logic [31:0]       signature_word_next;
  logic [31:0]       version_reg_next;
  logic [31:0]       stored_checksum_reg_next;
  logic [31:0]       seed_reg_next;

  logic              in_accept;
  logic [7:0]        data_byte;
  logic [31:0]       lane_word;
  logic [4:0]        lane_shift;
  logic [POS_W-1:0]  seed_off;
  logic [POS_W-1:0]  final_seed_off;
  logic              in_cks;
  logic              seed_hit;
  logic [1:0]        seed_idx;
  logic [4:0]        seed_shift;
  logic [7:0]        ob;
  logic [31:0]       repl_seed_shr;
  logic [31:0]       seed_shr_byte;
  status_t           status;
  result_t           res;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign data_byte = s_tdata[7:0];

  always_comb begin
    lane_shift = {byte_position[1:0], 3'b000};
    lane_word  = 32'(data_byte) << lane_shift;

    signature_word_next      = signature_word;
    version_reg_next         = version_reg;
    stored_checksum_reg_next = stored_checksum_reg;
    in_cks = (byte_position >= CHECKSUM_POS) && (byte_position < CHECKSUM_POS + 16'd4);

    if (byte_position < VERSION_POS) begin
      signature_word_next = signature_word | lane_word;
    end else if (byte_position < VERSION_POS + 16'd4) begin
      version_reg_next = version_reg | lane_word;
    end else if (in_cks) begin
      stored_checksum_reg_next = stored_checksum_reg | lane_word;
    end

    // seed offset uses the version as it stood before this item
    seed_off   = (version_reg >= VERSION_NEW_OFFSET) ? SEED_OFF_NEW : SEED_OFF_OLD;
    seed_hit   = (byte_position >= CHECKSUM_POS + 16'd4) && (byte_position >= seed_off) &&
                 (byte_position < seed_off + 16'd4);
    seed_idx   = byte_position[1:0] - seed_off[1:0];
    seed_shift = {seed_idx, 3'b000};
    repl_seed_shr = repl_seed >> seed_shift;
    seed_shr_byte = 32'(data_byte) << seed_shift;

    ob            = data_byte;
    seed_reg_next = seed_reg;
    if (seed_hit) begin
      seed_reg_next = seed_reg | seed_shr_byte;
      if (write_seed && (signature_word == SIGNATURE_VALUE)) begin
        ob = repl_seed_shr[7:0];
      end
    end

    checksum_accum_next = {checksum_accum[30:0], checksum_accum[31]} +
                          (in_cks ? 32'd0 : 32'(ob));

    byte_position_next = (byte_position < POS_MAX) ? byte_position + 16'd1 : byte_position;

    final_seed_off = (version_reg_next >= VERSION_NEW_OFFSET) ? SEED_OFF_NEW : SEED_OFF_OLD;
    priority if (byte_position_next < VERSION_POS + 16'd4) begin
      status = ST_SHORT;
    end else if (signature_word_next != SIGNATURE_VALUE) begin
      status = ST_BAD_SIG;
    end else if (byte_position_next < final_seed_off + 16'd4) begin
      status = ST_NO_SEED_ROOM;
    end else begin
      status = ST_OK;
    end

    res          = '0;
    res.out_byte = ob;
    if (s_tlast) begin
      res.status            = status;
      res.checksum_ok       = (stored_checksum_reg_next == checksum_accum_next);
      res.computed_checksum = checksum_accum_next;
      res.stored_checksum   = stored_checksum_reg_next;
      res.old_seed          = seed_reg_next;
      res.version_word      = version_reg_next;
      res.file_size         = byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_seed          <= 1'b0;
      repl_seed           <= '0;
      byte_position       <= '0;
      checksum_accum      <= '0;
      signature_word      <= '0;
      version_reg         <= '0;
      stored_checksum_reg <= '0;
      seed_reg            <= '0;
      m_tvalid            <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WRITE_SEED: write_seed <= cfg_data[0];
          CFG_REPL_SEED:  repl_seed  <= cfg_data;
          default:        repl_seed  <= repl_seed;
        endcase
      end

      if (in_accept) begin
        if (s_tlast) begin
          // end of file: next item starts a new stream
          byte_position       <= '0;
          checksum_accum      <= '0;
          signature_word      <= '0;
          version_reg         <= '0;
          stored_checksum_reg <= '0;
          seed_reg            <= '0;
        end else begin
          byte_position       <= byte_position_next;
          checksum_accum      <= checksum_accum_next;
          signature_word      <= signature_word_next;
          version_reg         <= version_reg_next;
          stored_checksum_reg <= stored_checksum_reg_next;
          seed_reg            <= seed_reg_next;
        end
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tdata <= res;
      m_tlast <= s_tlast;
    end
  end

endmodule

// File: design/shspc_checker.sv
// checker: port-level assertions for the save header seed patch checksum block
`timescale 1ns / 1ps

module shspc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               s_tlast,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [shspc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                               m_tlast
);
  import shspc_pkg::*;

  // output register empties on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // every accepted item shows up next cycle with its end-of-file mark
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid && (m_tlast == $past(s_tlast)))
    else $error("accepted item did not produce its result");

  // only the final item of a file carries summary fields
  a_summary_only_final: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[OUT_TDATA_W-1:8] == '0))
    else $error("summary fields set on a non-final item");

endmodule

bind save_header_seed_patch_checksum shspc_checker u_shspc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
